// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertions that share the block clock and synchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BKD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// same-cycle implication
`define BKD_ASSERT_IMPLIES(label, ante, cons, msg) \
   `BKD_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define BKD_ASSERT_NEXT(label, ante, cons, msg) \
   `BKD_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/bkd_pkg.sv =====
// ----------------------------------------------------------------------------
// bkd_pkg
// shared widths, constants and types of the base64 key decoder
// ----------------------------------------------------------------------------
package bkd_pkg;

   localparam int KEY_CHAR_W      = 8;
   localparam int SEXTET_W        = 6;
   localparam int COUNT_W         = 9;
   localparam int MAX_OUT_DEFAULT = 256;
   localparam int QUEUE_DEPTH     = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_OUT_LIMIT   = '0;
   localparam logic [COUNT_W-1:0]   OUT_LIMIT_RESET = COUNT_W'(255);

   localparam logic [KEY_CHAR_W-1:0] PRINT_LO = KEY_CHAR_W'(32);
   localparam logic [KEY_CHAR_W-1:0] PRINT_HI = KEY_CHAR_W'(126);

   typedef struct packed {
      logic [SEXTET_W-1:0] sextet;
      logic                bad;
      logic                last;
   } item_type;

   typedef struct packed {
      logic [KEY_CHAR_W-1:0] out_byte;
      logic                  byte_valid;
      logic                  done_res;
      logic                  stopped_early;
      logic [COUNT_W-1:0]    decoded_count;
      logic                  use_decoded;
   } result_type;

endpackage

// ===== rtl/bkd_if.sv =====
// ----------------------------------------------------------------------------
// bkd_if
// valid/ready channels for key characters and decoded results
// ----------------------------------------------------------------------------
interface bkd_req_if;
   import bkd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KEY_CHAR_W-1:0] key_char;
   logic                  last_char;

   modport source (output valid, output key_char, output last_char, input ready);
   modport sink   (input valid, input key_char, input last_char, output ready);
endinterface

interface bkd_rsp_if;
   import bkd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KEY_CHAR_W-1:0] out_byte;
   logic                  byte_valid;
   logic                  done_res;
   logic                  stopped_early;
   logic [COUNT_W-1:0]    decoded_count;
   logic                  use_decoded;

   modport source (
      output valid, output out_byte, output byte_valid, output done_res,
      output stopped_early, output decoded_count, output use_decoded,
      input ready
   );
   modport sink (
      input valid, input out_byte, input byte_valid, input done_res,
      input stopped_early, input decoded_count, input use_decoded,
      output ready
   );
endinterface

// ===== rtl/bkd_front.sv =====
// ----------------------------------------------------------------------------
// bkd_front
// accepts key characters and maps each to a six-bit value or a bad flag
// ----------------------------------------------------------------------------
module bkd_front (
   bkd_req_if.sink            req,
   output bkd_pkg::item_type  wr_data,
   output logic               wr_valid,
   input  logic               wr_ready
);
   import bkd_pkg::*;

   localparam logic [KEY_CHAR_W-1:0] CHAR_UPPER_A = KEY_CHAR_W'(8'h41);
   localparam logic [KEY_CHAR_W-1:0] CHAR_UPPER_Z = KEY_CHAR_W'(8'h5A);
   localparam logic [KEY_CHAR_W-1:0] CHAR_LOWER_A = KEY_CHAR_W'(8'h61);
   localparam logic [KEY_CHAR_W-1:0] CHAR_LOWER_Z = KEY_CHAR_W'(8'h7A);
   localparam logic [KEY_CHAR_W-1:0] CHAR_ZERO    = KEY_CHAR_W'(8'h30);
   localparam logic [KEY_CHAR_W-1:0] CHAR_NINE    = KEY_CHAR_W'(8'h39);
   localparam logic [KEY_CHAR_W-1:0] CHAR_PLUS    = KEY_CHAR_W'(8'h2B);
   localparam logic [KEY_CHAR_W-1:0] CHAR_SLASH   = KEY_CHAR_W'(8'h2F);

   localparam logic [KEY_CHAR_W-1:0] LOWER_BASE = KEY_CHAR_W'(26);
   localparam logic [KEY_CHAR_W-1:0] DIGIT_BASE = KEY_CHAR_W'(52);
   localparam logic [SEXTET_W-1:0]   PLUS_CODE  = SEXTET_W'(62);
   localparam logic [SEXTET_W-1:0]   SLASH_CODE = SEXTET_W'(63);

   // returns {bad, sextet}; sextet is zero for a bad character
   function automatic logic [SEXTET_W:0] classify(input logic [KEY_CHAR_W-1:0] c);
      logic [KEY_CHAR_W-1:0] d;
      d = '0;
      classify = {1'b1, {SEXTET_W{1'b0}}};
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         classify = {1'b0, d[SEXTET_W-1:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A + LOWER_BASE;
         classify = {1'b0, d[SEXTET_W-1:0]};
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO + DIGIT_BASE;
         classify = {1'b0, d[SEXTET_W-1:0]};
      end else if (c == CHAR_PLUS) begin
         classify = {1'b0, PLUS_CODE};
      end else if (c == CHAR_SLASH) begin
         classify = {1'b0, SLASH_CODE};
      end
   endfunction

   logic [SEXTET_W:0] class_w;

   assign class_w        = classify(req.key_char);
   assign wr_data.sextet = class_w[SEXTET_W-1:0];
   assign wr_data.bad    = class_w[SEXTET_W];
   assign wr_data.last   = req.last_char;
   assign wr_valid       = req.valid;
   assign req.ready      = wr_ready;

endmodule

// ===== rtl/bkd_queue.sv =====
// ----------------------------------------------------------------------------
// bkd_queue
// short fifo of classified characters between front and back
// ----------------------------------------------------------------------------
module bkd_queue (
   input  logic               clock,
   input  logic               reset,
   input  bkd_pkg::item_type  wr_data,
   input  logic               wr_valid,
   output logic               wr_ready,
   output bkd_pkg::item_type  rd_data,
   output logic               rd_valid,
   input  logic               rd_ready
);
   import bkd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/bkd_back.sv =====
// ----------------------------------------------------------------------------
// bkd_back
// group state machine: builds bytes from sextets, tracks count and limit
// ----------------------------------------------------------------------------
module bkd_back #(
   parameter int MAX_OUT = bkd_pkg::MAX_OUT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bkd_pkg::COUNT_W-1:0]    out_limit,
   input  bkd_pkg::item_type              rd_data,
   input  logic                           rd_valid,
   output logic                           rd_ready,
   bkd_rsp_if.source                      rsp
);
   import bkd_pkg::*;

   localparam int MAX_W = $clog2(MAX_OUT + 1);
   localparam int LIM_W = ((MAX_W > COUNT_W) ? MAX_W : COUNT_W) + 1;
   localparam logic [LIM_W-1:0] MAX_OUT_L = LIM_W'(MAX_OUT);

   typedef enum logic [1:0] {
      SLOT_FIRST,
      SLOT_SECOND,
      SLOT_THIRD,
      SLOT_FOURTH
   } slot_type;

   slot_type            slot_ff, slot_in;
   logic [SEXTET_W-1:0] held_ff, held_in;
   logic                padded_ff, padded_in;
   logic                halted_ff, halted_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic                print_ff, print_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          result_ff, result_in;

   logic                  pop, emit, at_limit;
   logic [KEY_CHAR_W-1:0] byte_val;
   logic [LIM_W-1:0]      limit_ext, limit_eff, total_plus3;

   assign rd_ready    = !rsp_valid_ff || rsp.ready;
   assign pop         = rd_valid && rd_ready;
   assign limit_ext   = LIM_W'(out_limit);
   assign limit_eff   = (limit_ext < MAX_OUT_L) ? limit_ext : MAX_OUT_L;
   assign total_plus3 = LIM_W'(total_ff) + LIM_W'(3);
   assign at_limit    = (total_plus3 >= limit_eff);

   always_comb begin
      slot_in      = slot_ff;
      held_in      = held_ff;
      padded_in    = padded_ff;
      halted_in    = halted_ff;
      total_in     = total_ff;
      print_in     = print_ff;
      emit         = 1'b0;
      byte_val     = '0;
      result_in    = result_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      if (pop) begin
         if (!halted_ff) begin
            case (slot_ff)
               SLOT_FIRST: begin
                  if (at_limit || rd_data.bad) begin
                     halted_in = 1'b1;
                  end else begin
                     held_in   = rd_data.sextet;
                     padded_in = 1'b0;
                     slot_in   = SLOT_SECOND;
                  end
               end
               SLOT_SECOND: begin
                  if (rd_data.bad) begin
                     halted_in = 1'b1;
                  end else begin
                     byte_val = {held_ff, rd_data.sextet[5:4]};
                     emit     = 1'b1;
                     held_in  = rd_data.sextet;
                     slot_in  = SLOT_THIRD;
                  end
               end
               SLOT_THIRD: begin
                  if (rd_data.bad) begin
                     padded_in = 1'b1;
                  end else begin
                     byte_val = {held_ff[3:0], rd_data.sextet[5:2]};
                     emit     = 1'b1;
                     held_in  = rd_data.sextet;
                  end
                  slot_in = SLOT_FOURTH;
               end
               SLOT_FOURTH: begin
                  if (!padded_ff && !rd_data.bad) begin
                     byte_val = {held_ff[1:0], rd_data.sextet};
                     emit     = 1'b1;
                  end
                  slot_in   = SLOT_FIRST;
                  padded_in = 1'b0;
                  held_in   = '0;
               end
               default: begin
                  slot_in = SLOT_FIRST;
               end
            endcase
            if (emit) begin
               total_in = total_ff + COUNT_W'(1);
               if (byte_val < PRINT_LO || byte_val > PRINT_HI) begin
                  print_in = 1'b0;
               end
            end
         end
         if (emit || rd_data.last) begin
            rsp_valid_in            = 1'b1;
            result_in.out_byte      = byte_val;
            result_in.byte_valid    = emit;
            result_in.done_res      = rd_data.last;
            result_in.stopped_early = halted_in;
            result_in.decoded_count = total_in;
            result_in.use_decoded   = rd_data.last && (total_in != '0) && print_in;
         end
         // end of string: back to a fresh string
         if (rd_data.last) begin
            slot_in   = SLOT_FIRST;
            held_in   = '0;
            padded_in = 1'b0;
            halted_in = 1'b0;
            total_in  = '0;
            print_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SLOT_FIRST;
         held_ff      <= '0;
         padded_ff    <= 1'b0;
         halted_ff    <= 1'b0;
         total_ff     <= '0;
         print_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         held_ff      <= held_in;
         padded_ff    <= padded_in;
         halted_ff    <= halted_in;
         total_ff     <= total_in;
         print_ff     <= print_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_byte      = result_ff.out_byte;
   assign rsp.byte_valid    = result_ff.byte_valid;
   assign rsp.done_res      = result_ff.done_res;
   assign rsp.stopped_early = result_ff.stopped_early;
   assign rsp.decoded_count = result_ff.decoded_count;
   assign rsp.use_decoded   = result_ff.use_decoded;

endmodule

// ===== rtl/base64_key_decoder.sv =====
// path: an accepted character is written into the queue, then its beat is registered in the back and driven on rsp
// throughput: one character per cycle while rsp takes its beats, set by the group update in the back
// a character that completes no byte and is not last gives no beat
// reset (synchronous): clears string state and queue, out_limit returns to 255
// ----------------------------------------------------------------------------
// base64_key_decoder
// streaming base64 key decoder with classify front, fifo and group back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_key_decoder #(
   parameter int MAX_OUT = bkd_pkg::MAX_OUT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   bkd_req_if.sink                          req,
   bkd_rsp_if.source                        rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bkd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bkd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bkd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import bkd_pkg::*;

   logic [COUNT_W-1:0]   out_limit_ff, out_limit_in;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_write;

   item_type q_wr_data, q_rd_data;
   logic     q_wr_valid, q_wr_ready;
   logic     q_rd_valid, q_rd_ready;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (csr_index == REG_OUT_LIMIT) ? CSR_DATA_W'(out_limit_ff) : '0;

   always_comb begin
      out_limit_in = out_limit_ff;
      if (csr_write && csr_index == REG_OUT_LIMIT) begin
         out_limit_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= OUT_LIMIT_RESET;
      end else begin
         out_limit_ff <= out_limit_in;
      end
   end

   bkd_front u_front (
      .req      (req),
      .wr_data  (q_wr_data),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready)
   );

   bkd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_data  (q_wr_data),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .rd_data  (q_rd_data),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready)
   );

   bkd_back #(
      .MAX_OUT (MAX_OUT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .out_limit (out_limit_ff),
      .rd_data   (q_rd_data),
      .rd_valid  (q_rd_valid),
      .rd_ready  (q_rd_ready),
      .rsp       (rsp)
   );

   `BKD_ASSERT_NEXT(a_accept_fills_queue, req.valid && req.ready, q_rd_valid, "accepted char lost")
   `BKD_ASSERT_IMPLIES(a_use_needs_done, rsp.valid && rsp.use_decoded, rsp.done_res && rsp.decoded_count != 0, "use_decoded off done")
   `BKD_ASSERT_IMPLIES(a_byte_counted, rsp.valid && rsp.byte_valid, rsp.decoded_count != 0, "byte not counted")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// base64 key decoder bench: directed and random key strings, one character
// per beat, checked against a decoder model kept in the bench; out_limit
// written over several settings including the extremes and read back; both
// channels idle at random and the result side holds off for long stretches
// ----------------------------------------------------------------------------
module tb;
   import bkd_pkg::*;

   localparam int DECODE_MAX_OUT = MAX_OUT_DEFAULT;
   localparam int SETTLE_CYCLES  = 6;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_CHARS   = 920;
   localparam int PHASE_CHARS    = 100;
   localparam int HOLD_CYCLES    = 150;
   localparam int NO_SEXTET      = -1;

   localparam logic [KEY_CHAR_W-1:0] PAD_CHAR = "=";
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_FOURTH = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] OUT_LIMIT_ADDR = {REG_OUT_LIMIT, 2'b00};

   typedef enum {FLOW_OPEN, FLOW_RANDOM, FLOW_TOGGLE, FLOW_SPARSE} flow_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bkd_req_if req_if ();
   bkd_rsp_if rsp_if ();

   base64_key_decoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // decoder state as the bench sees it
   logic [1:0]          grp_slot;
   logic [SEXTET_W-1:0] grp_held;
   logic                grp_padded;
   logic                key_halted;
   logic [COUNT_W-1:0]  key_bytes;
   logic                key_printable;
   logic [COUNT_W-1:0]  out_limit_copy;

   result_type            pending_decodes[$];
   result_type            oldest;
   logic [KEY_CHAR_W-1:0] key_buf[$];

   int            failures;
   int            cycle_count;
   int            chars_accepted;
   int            beats_checked;
   int            keys_sent;
   int            usable_keys;
   int            halted_keys;
   int            input_stall_cycles;
   int            random_chars;
   int            burst_left;
   int            hold_req;
   int            hold_left;
   int            flow_left;
   flow_mode_type flow_mode;

   always #2 clock = ~clock;

   function automatic int char_to_sextet(input logic [KEY_CHAR_W-1:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return NO_SEXTET;
   endfunction

   function automatic logic [KEY_CHAR_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] v);
      if (v < 26) return "A" + v;
      if (v < 52) return "a" + (v - 26);
      if (v < 62) return "0" + (v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   function automatic void clear_key_state();
      grp_slot      = SLOT_FIRST;
      grp_held      = '0;
      grp_padded    = 1'b0;
      key_halted    = 1'b0;
      key_bytes     = '0;
      key_printable = 1'b1;
   endfunction

   function automatic void decode_key_char(input logic [KEY_CHAR_W-1:0] ch, input logic is_last);
      int                    sext;
      int                    eff_limit;
      logic [SEXTET_W-1:0]   val;
      logic [KEY_CHAR_W-1:0] byte_out;
      logic                  emit;
      result_type            r;
      emit      = 1'b0;
      byte_out  = '0;
      eff_limit = (out_limit_copy < DECODE_MAX_OUT) ? int'(out_limit_copy) : DECODE_MAX_OUT;
      if (!key_halted) begin
         sext = char_to_sextet(ch);
         val  = (sext == NO_SEXTET) ? '0 : sext[SEXTET_W-1:0];
         case (grp_slot)
            SLOT_FIRST: begin
               if (int'(key_bytes) + 3 >= eff_limit || sext == NO_SEXTET) begin
                  key_halted = 1'b1;
               end else begin
                  grp_held   = val;
                  grp_padded = 1'b0;
                  grp_slot   = SLOT_SECOND;
               end
            end
            SLOT_SECOND: begin
               if (sext == NO_SEXTET) begin
                  key_halted = 1'b1;
               end else begin
                  byte_out = {grp_held, val[5:4]};
                  emit     = 1'b1;
                  grp_held = val;
                  grp_slot = SLOT_THIRD;
               end
            end
            SLOT_THIRD: begin
               if (sext == NO_SEXTET) begin
                  grp_padded = 1'b1;
               end else begin
                  byte_out = {grp_held[3:0], val[5:2]};
                  emit     = 1'b1;
                  grp_held = val;
               end
               grp_slot = SLOT_FOURTH;
            end
            default: begin
               if (!grp_padded && sext != NO_SEXTET) begin
                  byte_out = {grp_held[1:0], val};
                  emit     = 1'b1;
               end
               grp_slot   = SLOT_FIRST;
               grp_padded = 1'b0;
               grp_held   = '0;
            end
         endcase
         if (emit) begin
            key_bytes = key_bytes + 1'b1;
            if (byte_out < PRINT_LO || byte_out > PRINT_HI) key_printable = 1'b0;
         end
      end
      if (emit || is_last) begin
         r.out_byte      = emit ? byte_out : '0;
         r.byte_valid    = emit;
         r.done_res      = is_last;
         r.stopped_early = key_halted;
         r.decoded_count = key_bytes;
         r.use_decoded   = is_last && key_bytes != 0 && key_printable;
         pending_decodes.push_back(r);
         if (is_last) begin
            if (r.use_decoded) usable_keys++;
            if (key_halted) halted_keys++;
            clear_key_state();
         end
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_decodes.size() == 0) begin
               $error("unexpected result beat: out_byte %0h count %0d done %0b",
                      rsp_if.out_byte, rsp_if.decoded_count, rsp_if.done_res);
               failures++;
            end else begin
               oldest = pending_decodes.pop_front();
               check_field("out_byte", oldest.out_byte, rsp_if.out_byte);
               check_field("byte_valid", oldest.byte_valid, rsp_if.byte_valid);
               check_field("done_res", oldest.done_res, rsp_if.done_res);
               check_field("stopped_early", oldest.stopped_early, rsp_if.stopped_early);
               check_field("decoded_count", oldest.decoded_count, rsp_if.decoded_count);
               check_field("use_decoded", oldest.use_decoded, rsp_if.use_decoded);
               beats_checked++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            decode_key_char(req_if.key_char, req_if.last_char);
            chars_accepted++;
         end
         if (req_if.valid && !req_if.ready) input_stall_cycles++;
         if (psel && penable && pwrite && pready && paddr == OUT_LIMIT_ADDR) begin
            out_limit_copy = pwdata[COUNT_W-1:0];
         end
      end
   end

   // result side: changing stall pattern, long hold-off on request
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         rsp_if.ready = 1'b0;
         hold_left--;
      end else begin
         if (flow_left == 0) begin
            flow_mode = flow_mode_type'($urandom_range(0, 3));
            flow_left = $urandom_range(8, 60);
         end
         flow_left--;
         case (flow_mode)
            FLOW_OPEN:   rsp_if.ready = 1'b1;
            FLOW_RANDOM: rsp_if.ready = $urandom_range(0, 2) != 0;
            FLOW_TOGGLE: rsp_if.ready = ~rsp_if.ready;
            default:     rsp_if.ready = $urandom_range(0, 4) == 0;
         endcase
      end
   end

   task automatic send_char(input logic [KEY_CHAR_W-1:0] ch, input logic is_last);
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      end
      burst_left--;
      req_if.valid     = 1'b1;
      req_if.key_char  = ch;
      req_if.last_char = is_last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_key();
      int i;
      for (i = 0; i < key_buf.size(); i++) send_char(key_buf[i], i == key_buf.size() - 1);
      keys_sent++;
   endtask

   task automatic send_text(input string text);
      int i;
      key_buf.delete();
      for (i = 0; i < text.len(); i++) key_buf.push_back(text[i]);
      send_key();
   endtask

   task automatic wait_for_drain();
      req_if.valid = 1'b0;
      while (pending_decodes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [COUNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] read_back;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = is_write;
      paddr   = OUT_LIMIT_ADDR;
      pwdata  = is_write ? CSR_DATA_W'(value) : '0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      read_back = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      if (!is_write) check_field("out_limit", 32'(out_limit_copy), read_back);
   endtask

   task automatic set_out_limit(input logic [COUNT_W-1:0] value);
      wait_for_drain();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
   endtask

   function automatic logic [KEY_CHAR_W-1:0] random_byte(input logic printable);
      return printable ? KEY_CHAR_W'($urandom_range(PRINT_LO, PRINT_HI))
                       : KEY_CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [KEY_CHAR_W-1:0] random_bad_char();
      logic [KEY_CHAR_W-1:0] c;
      if ($urandom_range(0, 3) == 0) return PAD_CHAR;
      do c = KEY_CHAR_W'($urandom_range(0, 255)); while (char_to_sextet(c) != NO_SEXTET);
      return c;
   endfunction

   // standard encoding of n random bytes, padded to whole groups
   task automatic build_encoded(input int n, input logic printable);
      int                    i;
      logic [KEY_CHAR_W-1:0] b0, b1, b2;
      key_buf.delete();
      for (i = 0; i < n; i += 3) begin
         b0 = random_byte(printable);
         b1 = (n - i > 1) ? random_byte(printable) : '0;
         b2 = (n - i > 2) ? random_byte(printable) : '0;
         key_buf.push_back(sextet_to_char(b0[7:2]));
         key_buf.push_back(sextet_to_char({b0[1:0], b1[7:4]}));
         key_buf.push_back((n - i > 1) ? sextet_to_char({b1[3:0], b2[7:6]}) : PAD_CHAR);
         key_buf.push_back((n - i > 2) ? sextet_to_char(b2[5:0]) : PAD_CHAR);
      end
   endtask

   task automatic build_random_key();
      int flavor;
      flavor = $urandom_range(0, 9);
      if (flavor == 0) begin
         key_buf.delete();
         repeat ($urandom_range(1, 8)) key_buf.push_back(KEY_CHAR_W'($urandom_range(0, 255)));
      end else begin
         build_encoded(($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 12),
                       flavor <= 4);
         case ($urandom_range(0, 3))
            0: begin
               while (key_buf[key_buf.size() - 1] == PAD_CHAR) void'(key_buf.pop_back());
            end
            1: begin
               while (key_buf[key_buf.size() - 1] == PAD_CHAR) void'(key_buf.pop_back());
               if (key_buf.size() > 1) void'(key_buf.pop_back());
            end
            default: ;
         endcase
         if (flavor >= 8) key_buf[$urandom_range(0, key_buf.size() - 1)] = random_bad_char();
      end
   endtask

   task automatic test_register_reset();
      csr_access(1'b0, '0);
   endtask

   task automatic test_directed_keys();
      send_text("TWFu");
      send_text("AZaz09+/");
      send_text("TW=x");
      send_text("TWE=");
      send_text("QUI");
   endtask

   task automatic test_bad_chars();
      key_buf = '{8'h00, "A", 8'hFF};
      send_key();
      key_buf = '{"T", 8'hFF, "F", "u"};
      send_key();
   endtask

   task automatic test_low_limits();
      int unsigned low_limits[5] = '{0, 3, 4, 5, 7};
      int          i;
      for (i = 0; i < 5; i++) begin
         set_out_limit(COUNT_W'(low_limits[i]));
         send_text("TWFuTWFuQQ");
      end
   endtask

   task automatic test_output_limit();
      set_out_limit(9'h1FF);
      build_encoded(270, 1'b1);
      send_key();
   endtask

   task automatic test_backpressure();
      wait_for_drain();
      hold_req = HOLD_CYCLES;
      build_encoded(30, 1'b0);
      send_key();
      wait_for_drain();
   endtask

   task automatic test_random_keys();
      int phase;
      int phase_end;
      phase = 0;
      while (random_chars < RANDOM_CHARS) begin
         if (phase == 0) begin
            set_out_limit(COUNT_W'(DECODE_MAX_OUT));
         end else begin
            case ($urandom_range(0, 5))
               0: set_out_limit(OUT_LIMIT_RESET);
               1: set_out_limit(COUNT_W'(DECODE_MAX_OUT));
               2: set_out_limit(9'h1FF);
               3: set_out_limit(COUNT_W'($urandom_range(0, 7)));
               4: set_out_limit(COUNT_W'($urandom_range(8, 64)));
               default: set_out_limit(COUNT_W'($urandom_range(0, 511)));
            endcase
         end
         phase_end = random_chars + PHASE_CHARS;
         while (random_chars < phase_end) begin
            build_random_key();
            send_key();
            random_chars += key_buf.size();
         end
         phase++;
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.key_char  = '0;
      req_if.last_char = 1'b0;
      rsp_if.ready     = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      out_limit_copy   = OUT_LIMIT_RESET;
      clear_key_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_reset();
      test_directed_keys();
      test_bad_chars();
      test_low_limits();
      test_output_limit();
      test_backpressure();
      test_random_keys();
      wait_for_drain();

      $display("%0d keys, %0d characters and %0d result beats checked over %0d cycles",
               keys_sent, chars_accepted, beats_checked, cycle_count);
      $display("%0d keys usable as decoded, %0d halted early, input stalled for %0d cycles",
               usable_keys, halted_keys, input_stall_cycles);
      if (failures == 0 && pending_decodes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bkd_pkg.sv
rtl/bkd_if.sv
rtl/bkd_front.sv
rtl/bkd_queue.sv
rtl/bkd_back.sv
rtl/base64_key_decoder.sv
dv/tb.sv
